### rtl/tli_pkg.sv
// Package for the table linear interpolator: widths, status codes, queue types.
// Used by every module in rtl/; no other dependencies.
package tli_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SIZE_W = 5;
    localparam int KEY_W = 32;
    localparam int COEF_W = 16;
    localparam int PROD_W = KEY_W + COEF_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;
    localparam logic [1:0] ST_ZERO_WIDTH = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
    } query_t;

    typedef struct packed {
        logic [1:0] status;
        logic [COEF_W-1:0] refl;
        logic [COEF_W-1:0] trans;
    } result_t;

endpackage

### rtl/tli_front.sv
// Front end: accepts transactions, writes loads into the table, queues queries.
// Depends on tli_pkg.
module tli_front
    import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [3:0]        entry_index,
    input  logic [KEY_W-1:0]  key_value,
    input  logic [COEF_W-1:0] reflect_value,
    input  logic [COEF_W-1:0] transmit_value,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_idx,
    output logic [KEY_W-1:0]  wr_key,
    output logic [COEF_W-1:0] wr_refl,
    output logic [COEF_W-1:0] wr_trans,
    output logic              q_valid,
    input  logic              q_ready,
    output query_t            q_data,
    input  logic              back_idle
);
    // two-entry queue
    query_t     fifo_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic       push;
    logic       pop;
    logic       acc;

    // hold loads until queued queries drained so order with table is kept
    assign in_ready = (opcode == OP_QUERY) ? (cnt_reg != 2'd2)
                                           : (cnt_reg == 2'd0 && back_idle);
    assign acc = in_valid && in_ready;
    assign push = acc && opcode == OP_QUERY;
    assign pop = q_valid && q_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data = fifo_reg[rd_ptr_reg];

    assign wr_en = acc && opcode == OP_LOAD && {1'b0, entry_index} < 5'(TABLE_DEPTH);
    assign wr_idx = IDX_W'(entry_index);
    assign wr_key = key_value;
    assign wr_refl = reflect_value;
    assign wr_trans = transmit_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg].key <= key_value;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> cnt_reg == 2'd0 && back_idle) else $error("load overtook query");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count bad");
`endif
endmodule

### rtl/tli_divider.sv
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on tli_pkg.
module tli_divider
    import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [KEY_W-1:0]  divisor,
    output logic              busy,
    output logic [COEF_W-1:0] quotient
);
    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg;
    logic [KEY_W:0]    rem_reg;
    logic [KEY_W-1:0]  div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [KEY_W:0]    trial;
    logic [KEY_W:0]    shifted;

    assign busy = cnt_reg != '0;
    assign quotient = quo_reg[COEF_W-1:0];
    assign shifted = {rem_reg[KEY_W-1:0], quo_reg[PROD_W-1]};
    assign trial = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(PROD_W);
        else if (busy)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy)
        begin
            if (!trial[KEY_W])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end
endmodule

### rtl/tli_back.sv
// Back end: holds the table, searches the interval, interpolates both coefficients.
// Depends on tli_pkg and tli_divider.
module tli_back
    import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] table_size,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [COEF_W-1:0] wr_refl,
    input  logic [COEF_W-1:0] wr_trans,
    input  logic              q_valid,
    output logic              q_ready,
    input  query_t            q_data,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res_data
);
    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_MUL, S_DIV_R, S_DIV_T, S_DONE} state_t;

    logic [KEY_W-1:0]  bp_tab [TABLE_DEPTH];
    logic [COEF_W-1:0] rf_tab [TABLE_DEPTH];
    logic [COEF_W-1:0] tr_tab [TABLE_DEPTH];

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  last_idx;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  lo_reg, width_reg;
    logic [COEF_W-1:0] rb_reg, rt_reg, tb_reg, tt_reg;
    logic              rdown_reg, tdown_reg;
    logic [PROD_W-1:0] tprod_reg;
    logic [COEF_W-1:0] rq_reg;
    result_t           res_reg;
    logic              div_start;
    logic [PROD_W-1:0] div_num;
    logic              div_busy;
    logic [COEF_W-1:0] div_q;
    logic [COEF_W-1:0] rmag, tmag;
    logic [KEY_W-1:0]  dx;
    logic [PROD_W-1:0] rprod, tprod;
    result_t           srch_res;
    logic              srch_end;
    logic              srch_mul;

    always_comb
    begin
        if (table_size < SIZE_W'(2))
            last_idx = IDX_W'(1);
        else if (table_size > SIZE_W'(TABLE_DEPTH))
            last_idx = IDX_W'(TABLE_DEPTH - 1);
        else
            last_idx = IDX_W'(table_size - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bp_tab[wr_idx] <= wr_key;
            rf_tab[wr_idx] <= wr_refl;
            tr_tab[wr_idx] <= wr_trans;
        end
    end

    // one search step: finish on an out-of-range key, a found interval or the last entry
    always_comb
    begin
        srch_res = '0;
        srch_end = 1'b0;
        srch_mul = 1'b0;
        if (key_reg < bp_tab[0])
        begin
            srch_res.status = ST_BELOW;
            srch_end = 1'b1;
        end
        else if (key_reg > bp_tab[last_idx])
        begin
            srch_res.status = ST_ABOVE;
            srch_end = 1'b1;
        end
        else if (key_reg < bp_tab[i_reg])
        begin
            if (bp_tab[i_reg] <= bp_tab[i_reg - 1'b1] || key_reg < bp_tab[i_reg - 1'b1])
            begin
                srch_res.status = ST_ZERO_WIDTH;
                srch_end = 1'b1;
            end
            else
                srch_mul = 1'b1;
        end
        else if (i_reg == last_idx)
        begin
            // no breakpoint above the key: key sits on the last breakpoint
            srch_res.refl = rf_tab[last_idx];
            srch_res.trans = tr_tab[last_idx];
            srch_end = 1'b1;
        end
    end

    assign q_ready = state_reg == S_IDLE;
    assign idle = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res_data = res_reg;
    assign rmag = rdown_reg ? rb_reg - rt_reg : rt_reg - rb_reg;
    assign tmag = tdown_reg ? tb_reg - tt_reg : tt_reg - tb_reg;
    assign dx = key_reg - lo_reg;
    assign rprod = PROD_W'(dx) * PROD_W'(rmag);
    assign tprod = PROD_W'(dx) * PROD_W'(tmag);
    assign div_start = (state_reg == S_MUL) || (state_reg == S_DIV_R && !div_busy);
    assign div_num = (state_reg == S_MUL) ? rprod : tprod_reg;

    tli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (width_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_SEARCH;
            S_SEARCH:
            begin
                if (srch_end)
                    state_next = S_DONE;
                else if (srch_mul)
                    state_next = S_MUL;
            end
            S_MUL:    state_next = S_DIV_R;
            S_DIV_R:  if (!div_busy) state_next = S_DIV_T;
            S_DIV_T:  if (!div_busy) state_next = S_DONE;
            S_DONE:   if (res_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath: scan one breakpoint a cycle, then multiply, then divide twice
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                key_reg <= q_data.key;
                i_reg <= IDX_W'(1);
            end
            S_SEARCH:
            begin
                lo_reg <= bp_tab[i_reg - 1'b1];
                width_reg <= bp_tab[i_reg] - bp_tab[i_reg - 1'b1];
                rb_reg <= rf_tab[i_reg - 1'b1];
                rt_reg <= rf_tab[i_reg];
                tb_reg <= tr_tab[i_reg - 1'b1];
                tt_reg <= tr_tab[i_reg];
                rdown_reg <= rf_tab[i_reg] < rf_tab[i_reg - 1'b1];
                tdown_reg <= tr_tab[i_reg] < tr_tab[i_reg - 1'b1];
                res_reg <= srch_res;
                if (!srch_end && !srch_mul)
                    i_reg <= i_reg + 1'b1;
            end
            S_MUL:
                tprod_reg <= tprod;
            S_DIV_R:
                if (!div_busy)
                    rq_reg <= div_q;
            S_DIV_T:
                if (!div_busy)
                    res_reg <= {ST_OK,
                                rdown_reg ? rb_reg - rq_reg : rb_reg + rq_reg,
                                tdown_reg ? tb_reg - div_q : tb_reg + div_q};
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != ST_OK |-> res_data.refl == '0 && res_data.trans == '0)
        else $error("nonzero coefficient with bad status");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_IDLE) else $error("table written during query");
`endif
endmodule

### rtl/table_linear_interpolator_unit.sv
// Top level of the table linear interpolator: config register, front end, back end.
// Depends on tli_pkg, tli_front, tli_back, tli_divider.
//
// Usage: load entries with opcode 0 (no result), then query with opcode 1 (one
// result: reflect_out, transmit_out, status). Queries are worked one at a time.
// The back end scans one breakpoint a cycle. A query ends in the scan when it is
// out of range, falls in a zero-width interval or has its key on the last
// breakpoint. An interpolated query adds a multiply step and two passes of one
// shared radix-2 divider, one pass per coefficient. After the result transaction
// the back end returns to idle before it takes the next query. A two-entry query
// queue lets new queries be taken while one is being worked; a load waits until
// earlier queries are done. table_size is written through cfg_valid/cfg_ready;
// write it only while no transaction is in flight. It resets to 2 and is clamped
// to 2..16. The table holds no reset value.
module table_linear_interpolator_unit
    import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [3:0]        entry_index,
    input  logic [KEY_W-1:0]  key_value,
    input  logic [COEF_W-1:0] reflect_value,
    input  logic [COEF_W-1:0] transmit_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [COEF_W-1:0] reflect_out,
    output logic [COEF_W-1:0] transmit_out,
    output logic [1:0]        status
);
    logic [SIZE_W-1:0] size_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [KEY_W-1:0]  wr_key;
    logic [COEF_W-1:0] wr_refl, wr_trans;
    logic              q_valid, q_ready, back_idle;
    query_t            q_data;
    result_t           res;

    assign cfg_ready = 1'b1;

    // hold the table size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_W'(2);
        else if (cfg_valid)
            size_reg <= cfg_data;
    end

    tli_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_index(entry_index), .key_value(key_value),
        .reflect_value(reflect_value), .transmit_value(transmit_value),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_key(wr_key), .wr_refl(wr_refl),
        .wr_trans(wr_trans), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .back_idle(back_idle)
    );

    tli_back u_back (
        .clk(clk), .rst_n(rst_n), .table_size(size_reg), .wr_en(wr_en),
        .wr_idx(wr_idx), .wr_key(wr_key), .wr_refl(wr_refl), .wr_trans(wr_trans),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data), .idle(back_idle),
        .res_valid(out_valid), .res_ready(out_ready), .res_data(res)
    );

    assign reflect_out = res.refl;
    assign transmit_out = res.trans;
    assign status = res.status;
endmodule

### tb/tli_scoreboard.sv
// Scoreboard for table_linear_interpolator_unit: tracks the table and size, predicts
// each query result and compares it with what the block returns. Depends on tli_pkg.
`timescale 1ns / 100ps

module tli_scoreboard
    import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              opcode,
    input  logic [3:0]        entry_index,
    input  logic [KEY_W-1:0]  key_value,
    input  logic [COEF_W-1:0] reflect_value,
    input  logic [COEF_W-1:0] transmit_value,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [COEF_W-1:0] reflect_out,
    input  logic [COEF_W-1:0] transmit_out,
    input  logic [1:0]        status,
    output int                fail_count,
    output int                results_pending
);

    logic [KEY_W-1:0]  bp_tbl [TABLE_DEPTH];
    logic [COEF_W-1:0] refl_tbl [TABLE_DEPTH];
    logic [COEF_W-1:0] trans_tbl [TABLE_DEPTH];
    logic [SIZE_W-1:0] size_reg;
    result_t           expected_results [$];

    function automatic logic [COEF_W-1:0] blend(logic [COEF_W-1:0] base,
                                                logic [COEF_W-1:0] peak,
                                                logic [KEY_W-1:0] dx,
                                                logic [KEY_W-1:0] width);
        logic        down;
        logic [63:0] mag;
        logic [63:0] q;
        down = peak < base;
        mag = down ? 64'(base - peak) : 64'(peak - base);
        q = (64'(dx) * mag) / 64'(width);
        return down ? base - q[COEF_W-1:0] : base + q[COEF_W-1:0];
    endfunction

    function automatic result_t interpolate(logic [KEY_W-1:0] key);
        int               n;
        int               i;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        result_t          r;
        r = '0;
        r.status = ST_OK;
        n = int'(size_reg);
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (key < bp_tbl[0]) begin
            r.status = ST_BELOW;
        end else if (key > bp_tbl[n-1]) begin
            r.status = ST_ABOVE;
        end else begin
            i = 1;
            while (i < n && !(key < bp_tbl[i])) i++;
            if (i >= n) begin
                r.refl = refl_tbl[n-1];
                r.trans = trans_tbl[n-1];
            end else begin
                lo = bp_tbl[i-1];
                hi = bp_tbl[i];
                if (hi <= lo || key < lo) begin
                    r.status = ST_ZERO_WIDTH;
                end else begin
                    r.refl = blend(refl_tbl[i-1], refl_tbl[i], key - lo, hi - lo);
                    r.trans = blend(trans_tbl[i-1], trans_tbl[i], key - lo, hi - lo);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            size_reg = 5'd2;
            expected_results.delete();
            fail_count = 0;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                bp_tbl[k] = '0;
                refl_tbl[k] = '0;
                trans_tbl[k] = '0;
            end
        end else begin
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
            if (in_valid && in_ready) begin
                if (opcode == OP_LOAD) begin
                    bp_tbl[entry_index] = key_value;
                    refl_tbl[entry_index] = reflect_value;
                    trans_tbl[entry_index] = transmit_value;
                end else begin
                    expected_results.push_back(interpolate(key_value));
                end
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with none expected: status %0d", status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (reflect_out !== want.refl) begin
                        $error("reflect_out: expected %0d, actual %0d", want.refl,
                               reflect_out);
                        fail_count++;
                    end
                    if (transmit_out !== want.trans) begin
                        $error("transmit_out: expected %0d, actual %0d", want.trans,
                               transmit_out);
                        fail_count++;
                    end
                end
            end
        end
        results_pending = expected_results.size();
    end

endmodule

### tb/tb_top.sv
// Testbench top for table_linear_interpolator_unit: clock, reset, stimulus and verdict.
// Depends on tli_pkg, the block, and tli_scoreboard for prediction and checking.
`timescale 1ns / 100ps

module tb_top;
    import tli_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles with no transaction before giving up
    localparam int SETTLE = 300;         // longest query latency, with margin

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              opcode;
    logic [3:0]        entry_index;
    logic [KEY_W-1:0]  key_value;
    logic [COEF_W-1:0] reflect_value;
    logic [COEF_W-1:0] transmit_value;
    logic              out_valid;
    logic              out_ready;
    logic [COEF_W-1:0] reflect_out;
    logic [COEF_W-1:0] transmit_out;
    logic [1:0]        status;
    int                fail_count;
    int                results_pending;

    // Shaping state: the breakpoints we loaded, the size in force, idle rates.
    logic [KEY_W-1:0]  shadow_bp [TABLE_DEPTH];
    int                used_n;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                quiet_cycles;

    table_linear_interpolator_unit dut (.*);

    tli_scoreboard scoreboard (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: decide out_ready once per cycle, at the falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: count cycles in which no transaction moves on any channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("table_linear_interpolator_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one input transaction and hold it until the block takes it.
    // in_valid stays high afterwards so a following item can go back to back.
    task automatic send_item(logic op, logic [3:0] idx, logic [KEY_W-1:0] key,
                             logic [COEF_W-1:0] rv, logic [COEF_W-1:0] tv);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        key_value <= key;
        reflect_value <= rv;
        transmit_value <= tv;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then let in-flight work settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        used_n = (value < 2) ? 2 : (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        // Mostly legal Q1.15, sometimes any 16-bit value.
        return ($urandom_range(9) == 0) ? COEF_W'($urandom) : COEF_W'($urandom_range(32768));
    endfunction

    task automatic load_entry(int idx, logic [KEY_W-1:0] key);
        shadow_bp[idx] = key;
        send_item(OP_LOAD, 4'(idx), key, pick_coef(), pick_coef());
    endtask

    // Load all entries with ascending breakpoints; steps vary from zero to large.
    task automatic load_ascending_table();
        logic [63:0] k;
        k = $urandom_range(1000);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            load_entry(i, k[KEY_W-1:0]);
            case ($urandom_range(3))
                0: k = k;
                1: k = k + $urandom_range(1, 16);
                default: k = k + $urandom_range(1, 1 << 27);
            endcase
        end
    endtask

    // A query key aimed at the table: on a breakpoint, inside an interval, or off the ends.
    function automatic logic [KEY_W-1:0] pick_key();
        int          i;
        logic [63:0] span;
        i = $urandom_range(used_n - 1);
        case ($urandom_range(19))
            0, 1: return $urandom;
            2: return (shadow_bp[0] == 0) ? '0 : $urandom_range(shadow_bp[0] - 1);
            3: return (shadow_bp[used_n-1] == '1) ? '1
                      : $urandom_range(shadow_bp[used_n-1] + 1, 32'hFFFF_FFFF);
            4, 5: return shadow_bp[i];
            default: begin
                if (i == used_n - 1) return shadow_bp[i];
                span = 64'(shadow_bp[i+1]) - 64'(shadow_bp[i]);
                if (shadow_bp[i+1] <= shadow_bp[i]) return shadow_bp[i];
                return shadow_bp[i] + KEY_W'($urandom_range(32'(span - 1)));
            end
        endcase
    endfunction

    initial begin
        logic [SIZE_W-1:0] sizes [8];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        entry_index = '0;
        key_value = '0;
        reflect_value = '0;
        transmit_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        used_n = 2;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full table with extreme breakpoints and coefficients.
        write_size(5'd16);
        shadow_bp[0] = 32'h0000_0100;
        send_item(OP_LOAD, 4'd0, 32'h0000_0100, 16'd0, 16'd32768);
        send_item(OP_LOAD, 4'd1, 32'h0001_0000, 16'd32768, 16'd0);
        send_item(OP_LOAD, 4'd2, 32'h0001_0000, 16'hFFFF, 16'hFFFF);
        shadow_bp[1] = 32'h0001_0000;
        shadow_bp[2] = 32'h0001_0000;
        for (int i = 3; i < TABLE_DEPTH - 1; i++)
            load_entry(i, 32'h0001_0000 + KEY_W'(i) * 32'h0100_0000);
        send_item(OP_LOAD, 4'd15, 32'hFFFF_FFFE, 16'h5555, 16'hAAAA);
        shadow_bp[15] = 32'hFFFF_FFFE;
        send_item(OP_QUERY, 4'd0, 32'h0000_0000, 16'd0, 16'd0);  // below the table
        send_item(OP_QUERY, 4'd0, 32'h0000_0100, 16'd0, 16'd0);  // on first breakpoint
        send_item(OP_QUERY, 4'd0, 32'h0000_8080, 16'd0, 16'd0);  // rising and falling slopes
        send_item(OP_QUERY, 4'd0, 32'h0001_0000, 16'd0, 16'd0);  // duplicate breakpoint
        send_item(OP_QUERY, 4'd0, 32'hFFFF_FFFE, 16'd0, 16'd0);  // equal to last
        send_item(OP_QUERY, 4'd0, 32'hFFFF_FFFF, 16'd0, 16'd0);  // above the table
        send_item(OP_QUERY, 4'd0, 32'hFFFF_FFF0, 16'd0, 16'd0);  // last interval
        drain();

        // Random phases: each size setting, cycled through the idle patterns.
        sizes = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd7, 5'($urandom_range(3, 15))};
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            write_size(sizes[ph]);
            load_ascending_table();
            for (int j = 0; j < 110; j++) begin
                if ($urandom_range(19) == 0) begin
                    // Rewrite one entry with any breakpoint; the order may break.
                    load_entry($urandom_range(TABLE_DEPTH - 1), $urandom);
                end else begin
                    send_item(OP_QUERY, 4'($urandom), pick_key(), COEF_W'($urandom),
                              COEF_W'($urandom));
                end
                // Once in mid-phase, hold off until all results are back.
                if (j == 55) drain();
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (fail_count == 0)
            $display("table_linear_interpolator_unit verification clean");
        else
            $display("table_linear_interpolator_unit verification failed");
        $finish;
    end

endmodule

### files.f
rtl/tli_pkg.sv
rtl/tli_front.sv
rtl/tli_divider.sv
rtl/tli_back.sv
rtl/table_linear_interpolator_unit.sv
tb/tli_scoreboard.sv
tb/tb_top.sv
